[rtl/sbdd_pkg.sv]
package sbdd_pkg;

    localparam int BYTE_W     = 8;
    localparam int SAMPLE_W   = 32;
    localparam int REP_W      = 7;
    localparam int SEGW_W     = 5;
    localparam int ACC_W      = 31;
    localparam int CNT_W      = 16;
    localparam int DONE_W     = 17;
    localparam int BIDX_W     = 3;

    // Byte queue between the input side and the bit engine.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = 1;
    localparam int FIFO_CW    = 2;

    // Decoder phases.
    localparam logic [1:0] PH_COUNT = 2'd0;
    localparam logic [1:0] PH_WIDTH = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;

    typedef struct packed {
        logic                last;
        logic [REP_W-1:0]    repeat_res;
        logic [SAMPLE_W-1:0] sample;
    } result_t;

endpackage

[rtl/sbdd_byte_fifo.sv]
module sbdd_byte_fifo
    import sbdd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  logic [BYTE_W-1:0] wr_data,
    output logic              rd_valid,
    input  logic              rd_pop,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0]  mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] fill_reg, fill_next;
    logic               do_wr;
    logic               do_rd;

    assign wr_ready = (fill_reg != FIFO_CW'(FIFO_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = FIFO_AW'((FIFO_AW + 1)'(wr_ptr_reg) + 1'b1);
        end
        if (do_rd)
        begin
            rd_ptr_next = FIFO_AW'((FIFO_AW + 1)'(rd_ptr_reg) + 1'b1);
        end
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/sbdd_bit_engine.sv]
module sbdd_bit_engine
    import sbdd_pkg::*;
#(
    parameter int SUM_WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CNT_W-1:0]  sample_count,
    input  logic              byte_valid,
    input  logic [BYTE_W-1:0] byte_data,
    output logic              byte_pop,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res_data
);

    localparam int EXT_W = (SUM_WIDTH > SAMPLE_W) ? SUM_WIDTH : SAMPLE_W;

    logic                 cur_valid_reg, cur_valid_next;
    logic [BYTE_W-1:0]    cur_byte_reg, cur_byte_next;
    logic [BIDX_W-1:0]    bit_idx_reg, bit_idx_next;

    logic [1:0]           phase_reg, phase_next;
    logic [SEGW_W-1:0]    bcnt_reg, bcnt_next;
    logic [REP_W-1:0]     seg_count_reg, seg_count_next;
    logic [SEGW_W-1:0]    seg_width_reg, seg_width_next;
    logic [REP_W-1:0]     values_left_reg, values_left_next;
    logic [ACC_W-1:0]     accum_reg, accum_next;
    logic [SUM_WIDTH-1:0] sum_reg, sum_next;
    logic [DONE_W-1:0]    done_reg, done_next;

    logic                 out_valid_reg, out_valid_next;
    result_t              out_data_reg, out_data_next;

    logic                 bit_in;
    logic                 emit;
    logic                 seg_end;
    logic                 fin;
    logic                 out_free;
    logic                 step;
    logic                 byte_done;
    logic [REP_W-1:0]     rep;
    logic [DONE_W-1:0]    done_new;
    logic [SEGW_W-1:0]    width_new;
    logic [ACC_W-1:0]     accum_new;
    logic [SEGW_W-1:0]    width_m1;
    logic [SAMPLE_W-1:0]  neg_mask;
    logic [SAMPLE_W-1:0]  diff32;
    logic [EXT_W-1:0]     diff_ext;
    logic [EXT_W-1:0]     sum_ext;

    assign bit_in    = cur_byte_reg[bit_idx_reg];
    assign out_free  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    // Sign extension of a finished difference from seg_width bits.
    assign accum_new = {accum_reg[ACC_W-2:0], bit_in};
    assign width_m1  = seg_width_reg - 1'b1;
    assign neg_mask  = {SAMPLE_W{1'b1}} << seg_width_reg;
    assign diff32    = {1'b0, accum_new} | (accum_new[width_m1] ? neg_mask : '0);
    assign diff_ext  = EXT_W'(signed'(diff32));

    always_comb
    begin
        phase_next       = phase_reg;
        bcnt_next        = bcnt_reg + 1'b1;
        seg_count_next   = seg_count_reg;
        seg_width_next   = seg_width_reg;
        values_left_next = values_left_reg;
        accum_next       = accum_reg;
        sum_next         = sum_reg;
        done_next        = done_reg;
        emit             = 1'b0;
        seg_end          = 1'b0;
        rep              = REP_W'(1);
        width_new        = {seg_width_reg[SEGW_W-2:0], bit_in};

        unique case (phase_reg)
            PH_COUNT:
            begin
                seg_count_next = {seg_count_reg[REP_W-2:0], bit_in};
                if (bcnt_reg == SEGW_W'(REP_W - 1))
                begin
                    bcnt_next  = '0;
                    phase_next = PH_WIDTH;
                end
            end
            PH_WIDTH:
            begin
                seg_width_next = width_new;
                if (bcnt_reg == SEGW_W'(SEGW_W - 1))
                begin
                    bcnt_next = '0;
                    if (seg_count_reg == '0)
                    begin
                        phase_next = PH_COUNT;
                    end
                    else if (width_new == '0)
                    begin
                        // Zero width: the current sum stands for the whole segment.
                        phase_next = PH_COUNT;
                        emit       = 1'b1;
                        seg_end    = 1'b1;
                        rep        = seg_count_reg;
                    end
                    else
                    begin
                        values_left_next = seg_count_reg;
                        accum_next       = '0;
                        phase_next       = PH_VALUE;
                    end
                end
            end
            PH_VALUE:
            begin
                accum_next = accum_new;
                if (bcnt_reg == width_m1)
                begin
                    bcnt_next        = '0;
                    accum_next       = '0;
                    sum_next         = sum_reg + diff_ext[SUM_WIDTH-1:0];
                    values_left_next = values_left_reg - 1'b1;
                    seg_end          = (values_left_reg == REP_W'(1));
                    emit             = 1'b1;
                    if (seg_end)
                    begin
                        phase_next = PH_COUNT;
                    end
                end
            end
            default:
            begin
                bcnt_next  = '0;
                phase_next = PH_COUNT;
            end
        endcase

        done_new = done_reg + DONE_W'(rep);
        fin      = emit && seg_end && (done_new >= DONE_W'(sample_count));
        if (emit)
        begin
            done_next = done_new;
        end

        sum_ext = EXT_W'(sum_next);
        out_data_next.sample     = sum_ext[SAMPLE_W-1:0];
        out_data_next.repeat_res = rep;
        out_data_next.last       = fin;

        // End of spectrum: start over and drop the rest of the byte.
        if (fin)
        begin
            phase_next       = PH_COUNT;
            bcnt_next        = '0;
            seg_count_next   = '0;
            seg_width_next   = '0;
            values_left_next = '0;
            accum_next       = '0;
            sum_next         = '0;
            done_next        = '0;
        end
    end

    assign step      = cur_valid_reg && (!emit || out_free);
    assign byte_done = step && ((bit_idx_reg == '0) || fin);
    assign byte_pop  = byte_valid && (!cur_valid_reg || byte_done);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_byte_next  = cur_byte_reg;
        bit_idx_next   = bit_idx_reg;
        if (step)
        begin
            bit_idx_next = bit_idx_reg - 1'b1;
        end
        if (byte_pop)
        begin
            cur_valid_next = 1'b1;
            cur_byte_next  = byte_data;
            bit_idx_next   = BIDX_W'(BYTE_W - 1);
        end
        else if (byte_done)
        begin
            cur_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = step && emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg   <= 1'b0;
            bit_idx_reg     <= '0;
            phase_reg       <= PH_COUNT;
            bcnt_reg        <= '0;
            seg_count_reg   <= '0;
            seg_width_reg   <= '0;
            values_left_reg <= '0;
            accum_reg       <= '0;
            sum_reg         <= '0;
            done_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            bit_idx_reg   <= bit_idx_next;
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                phase_reg       <= phase_next;
                bcnt_reg        <= bcnt_next;
                seg_count_reg   <= seg_count_next;
                seg_width_reg   <= seg_width_next;
                values_left_reg <= values_left_next;
                accum_reg       <= accum_next;
                sum_reg         <= sum_next;
                done_reg        <= done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_byte_reg <= cur_byte_next;
        if (out_free && step && emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

[rtl/segment_bitpack_delta_decoder.sv]
// Decodes a bit-packed spectrum delivered one byte per input transaction, bits read most
// significant first. Each segment carries a 7-bit count and a 5-bit width, then count
// two's-complement differences of that width that are summed into a running sample; a
// zero-width segment yields one result holding the count as its repeat. The result that
// ends a segment with the sample total at or above sample_count is flagged with tlast,
// the rest of that byte is dropped and decoding restarts. Bytes go into a two-entry
// queue and a bit-serial engine consumes one bit per clock, taking up the next byte as
// the last bit of the current one is used; a byte may produce up to eight results, one
// per cycle, and the engine pauses only while the output register is held by a stalled
// downstream side. tdata carries the sample in bits 31:0, the repeat count in 38:32.
module segment_bitpack_delta_decoder
    import sbdd_pkg::*;
#(
    parameter int SUM_WIDTH = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CNT_W-1:0]            cfg_data,      // sample_count
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [BYTE_W-1:0]           s_axis_tdata,  // in_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [SAMPLE_W+REP_W:0]     m_axis_tdata,  // sample, repeat_res, zero pad
    output logic                        m_axis_tlast
);

    logic [CNT_W-1:0]  sample_count_reg;
    logic              q_valid;
    logic              q_pop;
    logic [BYTE_W-1:0] q_data;
    result_t           res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= CNT_W'(1);
        end
        else if (cfg_valid)
        begin
            sample_count_reg <= cfg_data;
        end
    end

    sbdd_byte_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (s_axis_tvalid),
        .wr_ready (s_axis_tready),
        .wr_data  (s_axis_tdata),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_data)
    );

    sbdd_bit_engine #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_engine
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_count (sample_count_reg),
        .byte_valid   (q_valid),
        .byte_data    (q_data),
        .byte_pop     (q_pop),
        .res_valid    (m_axis_tvalid),
        .res_ready    (m_axis_tready),
        .res_data     (res)
    );

    assign m_axis_tdata = {1'b0, res.repeat_res, res.sample};
    assign m_axis_tlast = res.last;

endmodule

[tb/spectrum_result_checker.sv]
`timescale 1ns / 1ps

module spectrum_result_checker
    import sbdd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CNT_W-1:0]        cfg_data,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [BYTE_W-1:0]       s_axis_tdata,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [SAMPLE_W+REP_W:0] m_axis_tdata,
    input  logic                    m_axis_tlast,
    output int                      mismatches,
    output int                      samples_owed,
    output int                      samples_checked,
    output int                      spectra_closed
);

    result_t             pending_results[$];

    // Decoder state as seen from the stream.
    logic [CNT_W-1:0]    spec_len;
    logic [1:0]          dec_phase;
    logic [4:0]          bit_pos;
    logic [REP_W-1:0]    seg_cnt;
    logic [SEGW_W-1:0]   seg_w;
    logic [REP_W-1:0]    vals_left;
    logic [31:0]         val_acc;
    logic [SAMPLE_W-1:0] run_sum;
    logic [DONE_W-1:0]   emitted;

    task automatic rearm();
        dec_phase = PH_COUNT;
        bit_pos   = '0;
        seg_cnt   = '0;
        seg_w     = '0;
        vals_left = '0;
        val_acc   = '0;
        run_sum   = '0;
        emitted   = '0;
    endtask

    // Queues one expected result and tells whether it closes the spectrum.
    function automatic logic owe_result(input logic [REP_W-1:0] rep, input logic seg_end);
        result_t r;
        emitted      = emitted + DONE_W'(rep);
        r.sample     = run_sum;
        r.repeat_res = rep;
        r.last       = seg_end && (emitted >= DONE_W'(spec_len));
        pending_results.push_back(r);
        return r.last;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t     want;
        logic        bitv;
        logic        closed;
        logic [31:0] mask;
        logic [31:0] diff;
        int          i;
        if (!rst_n)
        begin
            spec_len = CNT_W'(1);
            rearm();
            pending_results.delete();
            mismatches      = 0;
            samples_owed    = 0;
            samples_checked = 0;
            spectra_closed  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                spec_len = cfg_data;

            if (s_axis_tvalid && s_axis_tready)
            begin
                closed = 1'b0;
                for (i = BYTE_W - 1; i >= 0 && !closed; i--)
                begin
                    bitv = s_axis_tdata[i];
                    case (dec_phase)
                        PH_COUNT:
                        begin
                            seg_cnt = {seg_cnt[REP_W-2:0], bitv};
                            bit_pos++;
                            if (bit_pos == REP_W)
                            begin
                                bit_pos   = '0;
                                dec_phase = PH_WIDTH;
                            end
                        end
                        PH_WIDTH:
                        begin
                            seg_w = {seg_w[SEGW_W-2:0], bitv};
                            bit_pos++;
                            if (bit_pos == SEGW_W)
                            begin
                                bit_pos = '0;
                                if (seg_cnt == 0)
                                    dec_phase = PH_COUNT;
                                else if (seg_w == 0)
                                begin
                                    dec_phase = PH_COUNT;
                                    closed    = owe_result(seg_cnt, 1'b1);
                                end
                                else
                                begin
                                    vals_left = seg_cnt;
                                    val_acc   = '0;
                                    dec_phase = PH_VALUE;
                                end
                            end
                        end
                        default:
                        begin
                            val_acc = {val_acc[30:0], bitv};
                            bit_pos++;
                            if (bit_pos >= seg_w)
                            begin
                                // Sign-extend the difference from its segment width.
                                mask = (32'd1 << seg_w) - 32'd1;
                                diff = val_acc & mask;
                                if (diff[seg_w - 1])
                                    diff = diff | ~mask;
                                bit_pos   = '0;
                                val_acc   = '0;
                                run_sum   = run_sum + diff;
                                vals_left = vals_left - 1'b1;
                                if (vals_left == 0)
                                    dec_phase = PH_COUNT;
                                closed = owe_result(REP_W'(1), vals_left == 0);
                            end
                        end
                    endcase
                end
                // The rest of the byte is padding once the spectrum has ended.
                if (closed)
                    rearm();
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: sample %0d repeat %0d last %0b",
                                 $signed(m_axis_tdata[SAMPLE_W-1:0]),
                                 m_axis_tdata[SAMPLE_W+REP_W-1:SAMPLE_W], m_axis_tlast);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[SAMPLE_W-1:0] !== want.sample
                        || m_axis_tdata[SAMPLE_W+REP_W-1:SAMPLE_W] !== want.repeat_res
                        || m_axis_tlast !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $write("result %0d: expected sample %0d repeat %0d last %0b,",
                                   samples_checked, $signed(want.sample), want.repeat_res,
                                   want.last);
                            $display(" got sample %0d repeat %0d last %0b",
                                     $signed(m_axis_tdata[SAMPLE_W-1:0]),
                                     m_axis_tdata[SAMPLE_W+REP_W-1:SAMPLE_W], m_axis_tlast);
                        end
                    end
                    samples_checked++;
                    if (want.last)
                        spectra_closed++;
                end
            end

            samples_owed = pending_results.size();
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import sbdd_pkg::*;

    localparam int LIMIT_CYCLES  = 500000;
    localparam int SETTLE_CYCLES = 48;
    localparam int PHASES        = 8;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_mode_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CNT_W-1:0]        cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [BYTE_W-1:0]       s_axis_tdata;   // in_byte
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b1;
    logic [SAMPLE_W+REP_W:0] m_axis_tdata;   // sample, repeat_res, zero pad
    logic                    m_axis_tlast;

    int       mismatches;
    int       samples_owed;
    int       samples_checked;
    int       spectra_closed;

    // Bits of the packed stream not yet grouped into a byte.
    bit       stream_bits[$];
    int       spec_total;
    bit       spec_ended;
    int       cur_count;
    int       burst_left;
    bit       gaps_on;
    int       bytes_sent;
    int       cfg_writes;
    int       cycle_count;
    int       rx_tick;
    rx_mode_t rx_mode;

    always #5 clk = ~clk;

    segment_bitpack_delta_decoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    spectrum_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .mismatches      (mismatches),
        .samples_owed    (samples_owed),
        .samples_checked (samples_checked),
        .spectra_closed  (spectra_closed)
    );

    // Result side: m_axis_tready follows a stall pattern picked at random from four modes.
    always @(negedge clk)
    begin
        rx_tick++;
        if (rx_tick % 64 == 0)
            rx_mode = rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:     m_axis_tready <= 1'b1;
            RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 9) < 7);
            RX_PERIODIC: m_axis_tready <= (rx_tick % 8 < 5);
            default:     m_axis_tready <= (rx_tick % 32 >= 20);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (samples_owed != 0)
            @(negedge clk);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (burst_left == 0)
        begin
            if (gaps_on)
                repeat ($urandom_range(1, 6))
                begin
                    @(negedge clk);
                    s_axis_tvalid <= 1'b0;
                end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        if ($urandom_range(0, 63) == 0)
            drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Appends n bits, most significant first, and sends every whole byte.
    task automatic push_bits(input logic [31:0] v, input int n);
        logic [BYTE_W-1:0] b;
        int                k;
        for (k = n - 1; k >= 0; k--)
            stream_bits.push_back(v[k]);
        while (stream_bits.size() >= BYTE_W)
        begin
            for (k = BYTE_W - 1; k >= 0; k--)
                b[k] = stream_bits.pop_front();
            send_byte(b);
        end
    endtask

    task automatic seg_header(input int cnt, input int w);
        push_bits(cnt, REP_W);
        push_bits(w, SEGW_W);
        // Only a segment that emits can end the spectrum.
        if (cnt != 0)
        begin
            spec_total += cnt;
            if (spec_total >= cur_count)
                spec_ended = 1'b1;
        end
    endtask

    task automatic close_spectrum();
        int pad;
        pad = (BYTE_W - stream_bits.size() % BYTE_W) % BYTE_W;
        if (pad != 0)
            push_bits($urandom, pad);
        spec_total = 0;
        spec_ended = 1'b0;
    endtask

    task automatic random_segment();
        int pick;
        int cnt;
        int w;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            cnt = 0;
            w   = $urandom_range(0, 31);
        end
        else if (pick < 25)
        begin
            w   = 0;
            cnt = ($urandom_range(0, 3) == 0) ? 127 : $urandom_range(1, 127);
        end
        else if (pick < 32)
        begin
            cnt = $urandom_range(4, 8);
            w   = 31;
        end
        else
        begin
            cnt = $urandom_range(1, 6);
            w   = $urandom_range(1, 12);
        end
        seg_header(cnt, w);
        if (w != 0)
            repeat (cnt) push_bits($urandom, w);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_count = v;
        cfg_writes++;
    endtask

    initial
    begin : stimulus
        int targets [PHASES];
        int budget;
        int p;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cur_count     = 1;
        gaps_on       = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed spectra with the count at its reset value of one.
        seg_header(0, 31);
        seg_header(127, 0);
        close_spectrum();
        seg_header(3, 31);
        push_bits(32'h7FFF_FFFF, 31);
        push_bits(32'h4000_0000, 31);
        push_bits(32'h3FFF_FFFF, 31);
        close_spectrum();
        seg_header(2, 1);
        push_bits(1, 1);
        push_bits(0, 1);
        close_spectrum();
        seg_header(0, 0);
        seg_header(1, 0);
        close_spectrum();

        targets = '{0, 2, 20, 1, 65535, 5, 0, 0};
        targets[6] = $urandom_range(1, 40);
        targets[7] = $urandom_range(2, 12);
        for (p = 0; p < PHASES; p++)
        begin
            settle();
            write_count(CNT_W'(targets[p]));
            gaps_on = ($urandom_range(0, 3) != 0);
            if (targets[p] == 65535)
            begin
                // Leave this spectrum open so the next count lands in the middle of it.
                budget = bytes_sent + 30;
                while (bytes_sent < budget && !spec_ended)
                    random_segment();
                if (spec_ended)
                    close_spectrum();
            end
            else
            begin
                budget = bytes_sent + 55;
                while (bytes_sent < budget)
                begin
                    while (!spec_ended)
                        random_segment();
                    close_spectrum();
                end
            end
        end

        // Unstructured bytes at the end.
        gaps_on = 1'b1;
        repeat (24) send_byte(BYTE_W'($urandom));

        settle();
        $display("covered %0d bytes under %0d count settings (zero and 65535 among them),",
                 bytes_sent, cfg_writes);
        $display("%0d results checked, %0d spectra ended", samples_checked, spectra_closed);
        if (mismatches == 0 && samples_owed == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
